>>> hdl/bpwb_pkg.sv
`default_nettype none
package bpwb_pkg;

  // The bright set is one twentieth of the gathered pixels.
  localparam int unsigned BrightDiv = 20;
  localparam int unsigned BrightRemW = 5;

  typedef enum logic [1:0] {
    CMD_GATHER,
    CMD_GATHER_LAST,
    CMD_CORRECT
  } cmd_kind_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
  } result_t;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } cmd_t;

endpackage
`default_nettype wire

>>> hdl/bpwb_front.sv
`default_nettype none
module bpwb_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  bpwb_pkg::pixel_t pixel_i,
  input  wire              push,
  output logic             full,
  output bpwb_pkg::cmd_t   cmd_o,
  output logic             cmd_empty_o,
  input  wire              cmd_pop_i
);

  bpwb_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;
  bpwb_pkg::cmd_t cmd_new;

  assign full        = (cnt_q == 2'd2);
  assign cmd_empty_o = (cnt_q == 2'd0);
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && !cmd_empty_o;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    cmd_new.blue  = pixel_i.pixel_blue;
    cmd_new.green = pixel_i.pixel_green;
    cmd_new.red   = pixel_i.pixel_red;
    if (pixel_i.operation) begin
      cmd_new.kind = bpwb_pkg::CMD_CORRECT;
    end else if (pixel_i.frame_end) begin
      cmd_new.kind = bpwb_pkg::CMD_GATHER_LAST;
    end else begin
      cmd_new.kind = bpwb_pkg::CMD_GATHER;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/bpwb_hist.sv
`default_nettype none
module bpwb_hist #(
  parameter int unsigned CountW = 22
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire  [7:0]        rd_addr_i,
  output logic [CountW-1:0] rd_data_o,
  input  wire               wr_en_i,
  input  wire  [7:0]        wr_addr_i,
  input  wire  [CountW-1:0] wr_data_i,
  input  wire               clear_i
);

  logic [CountW-1:0] bin_mem [256];
  logic [255:0]      valid_q;
  logic [CountW-1:0] rd_q;
  logic              rd_valid_q;

  // A bin that has not been written since the last clear reads as zero.
  assign rd_data_o = rd_valid_q ? rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      bin_mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= bin_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr_i];
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/bpwb_div.sv
`default_nettype none
module bpwb_div #(
  parameter int unsigned NumW = 54,
  parameter int unsigned DenW = 30
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  wire  [NumW-1:0] num_i,
  input  wire  [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [DenW-1:0] den_q, rem_q;
  logic [NumW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [DenW:0]   shifted, diff;
  logic            fits;

  assign shifted = {rem_q, quo_q[NumW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = (shifted >= {1'b0, den_q});
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DenW-1:0] : shifted[DenW-1:0];
      quo_q <= {quo_q[NumW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

>>> hdl/bright_pixel_white_balance.sv
`default_nettype none
// White balance on the brightest five percent of a frame. Send each frame twice: first
// as gather pixels (operation 0, frame_end on the last), then as correct pixels
// (operation 1), which each return one result. A two-entry queue takes pixels while the
// back end works; the back end handles one pixel at a time. A gather pixel goes through
// dequeue, histogram read and histogram write, and a correct pixel through dequeue,
// multiply and round into the result register. The last gather pixel then runs the gain
// update: it walks the 256 histogram bins, one read and one accumulate per bin, and
// runs up to three divisions in one shared serial divider, one per channel whose sum
// is not zero; a frame too small for a bright set just resets the gains to one.
// Histograms clear at once through per-bin valid bits, so no clearing pass is needed.
module bright_pixel_white_balance #(
  parameter int unsigned PIXEL_COUNT_BITS = 22,
  parameter int unsigned GAIN_FRAC_BITS   = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  bpwb_pkg::pixel_t   pixel_i,
  input  wire                push,
  output logic               full,
  output bpwb_pkg::result_t  result_o,
  output logic               empty,
  input  wire                pop
);

  localparam int unsigned P     = PIXEL_COUNT_BITS;
  localparam int unsigned F     = GAIN_FRAC_BITS;
  localparam int unsigned SumW  = P + 8;
  localparam int unsigned NumW  = SumW + F;
  localparam int unsigned GainW = 8 + F;
  localparam int unsigned ProdW = 8 + GainW;
  localparam logic [P-1:0]     CntMax  = '1;
  localparam logic [GainW-1:0] GainOne = GainW'(1) << F;
  localparam logic [GainW-1:0] GainMax = '1;
  localparam logic [ProdW:0]   RoundHalf = (ProdW + 1)'(1) << (F - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_G_RD, S_G_WR, S_W_PREP, S_W_RD, S_W_ACC,
    S_MAX, S_DIV, S_DIV_WAIT, S_C_MUL, S_C_OUT
  } state_e;

  state_e                         state_q;
  bpwb_pkg::cmd_t                 cmd, cur_q;
  logic                           cmd_empty, cmd_pop;
  logic [P-1:0]                   count_q, k_q;
  logic [bpwb_pkg::BrightRemW-1:0] rem_q;
  logic [7:0]                     bin_q;
  logic [1:0]                     ch_q;
  logic [SumW-1:0]                sum_q [3];
  logic [P-1:0]                   left_q [3];
  logic [SumW-1:0]                mx_q;
  logic [GainW-1:0]               gain_q [3];
  logic [ProdW-1:0]               prod_q [3];
  logic                           out_vld_q;
  bpwb_pkg::result_t              out_q;

  logic [7:0]      px [3];
  logic [7:0]      hist_addr [3];
  logic [P-1:0]    hist_data [3];
  logic [P-1:0]    take [3];
  logic [SumW-1:0] weighted [3];
  logic [7:0]      corr [3];
  logic            hist_we, hist_clr, out_load, div_start, div_done;
  logic [NumW-1:0] quo;
  logic [GainW-1:0] quo_sat;

  bpwb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pixel_i     (pixel_i),
    .push        (push),
    .full        (full),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty),
    .cmd_pop_i   (cmd_pop)
  );

  assign px[0] = cur_q.blue;
  assign px[1] = cur_q.green;
  assign px[2] = cur_q.red;

  assign cmd_pop  = (state_q == S_IDLE) && !cmd_empty;
  assign hist_we  = (state_q == S_G_WR);
  assign hist_clr = ((state_q == S_W_PREP) && (k_q == '0)) ||
                    ((state_q == S_W_ACC) && (bin_q == 8'd0));
  assign out_load = (state_q == S_C_OUT) && (!out_vld_q || pop);
  assign div_start = (state_q == S_DIV) && (sum_q[ch_q] != '0);

  for (genvar c = 0; c < 3; c++) begin : g_chan
    assign hist_addr[c] = (state_q == S_W_RD) ? bin_q : px[c];
    assign take[c]      = (hist_data[c] < left_q[c]) ? hist_data[c] : left_q[c];
    assign weighted[c]  = SumW'(take[c]) * SumW'(bin_q);

    bpwb_hist #(
      .CountW (P)
    ) u_hist (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .rd_addr_i (hist_addr[c]),
      .rd_data_o (hist_data[c]),
      .wr_en_i   (hist_we),
      .wr_addr_i (px[c]),
      .wr_data_i ((hist_data[c] == CntMax) ? hist_data[c] : hist_data[c] + P'(1)),
      .clear_i   (hist_clr)
    );

    always_comb begin
      logic [ProdW:0] rounded;
      rounded = {1'b0, prod_q[c]} + RoundHalf;
      if (rounded[ProdW:F] > (ProdW + 1 - F)'(255)) begin
        corr[c] = 8'd255;
      end else begin
        corr[c] = rounded[F+7:F];
      end
    end
  end

  bpwb_div #(
    .NumW (NumW),
    .DenW (SumW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({mx_q, F'(0)}),
    .den_i   (sum_q[ch_q]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign quo_sat  = (quo[NumW-1:GainW] != '0) ? GainMax : quo[GainW-1:0];
  assign empty    = !out_vld_q;
  assign result_o = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_pop) cur_q <= cmd;
    if (state_q == S_C_MUL) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= ProdW'(px[c]) * ProdW'(gain_q[c]);
      end
    end
    if (out_load) begin
      out_q.out_blue  <= corr[0];
      out_q.out_green <= corr[1];
      out_q.out_red   <= corr[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      k_q       <= '0;
      rem_q     <= '0;
      bin_q     <= '0;
      ch_q      <= '0;
      mx_q      <= '0;
      out_vld_q <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        sum_q[c]  <= '0;
        left_q[c] <= '0;
        gain_q[c] <= GainOne;
      end
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (pop && out_vld_q) begin
        out_vld_q <= 1'b0;
      end
      if (hist_clr) begin
        count_q <= '0;
        k_q     <= '0;
        rem_q   <= '0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!cmd_empty) begin
            state_q <= (cmd.kind == bpwb_pkg::CMD_CORRECT) ? S_C_MUL : S_G_RD;
          end
        end
        S_G_RD: state_q <= S_G_WR;
        S_G_WR: begin
          // The count saturates; K follows it through a divide-by-twenty counter.
          if (count_q != CntMax) begin
            count_q <= count_q + P'(1);
            if (rem_q == bpwb_pkg::BrightRemW'(bpwb_pkg::BrightDiv - 1)) begin
              rem_q <= '0;
              k_q   <= k_q + P'(1);
            end else begin
              rem_q <= rem_q + bpwb_pkg::BrightRemW'(1);
            end
          end
          state_q <= (cur_q.kind == bpwb_pkg::CMD_GATHER_LAST) ? S_W_PREP : S_IDLE;
        end
        S_W_PREP: begin
          if (k_q == '0) begin
            for (int c = 0; c < 3; c++) gain_q[c] <= GainOne;
            state_q <= S_IDLE;
          end else begin
            for (int c = 0; c < 3; c++) begin
              sum_q[c]  <= '0;
              left_q[c] <= k_q;
            end
            bin_q   <= 8'd255;
            state_q <= S_W_RD;
          end
        end
        S_W_RD: state_q <= S_W_ACC;
        S_W_ACC: begin
          for (int c = 0; c < 3; c++) begin
            sum_q[c]  <= sum_q[c] + weighted[c];
            left_q[c] <= left_q[c] - take[c];
          end
          if (bin_q == 8'd0) begin
            state_q <= S_MAX;
          end else begin
            bin_q   <= bin_q - 8'd1;
            state_q <= S_W_RD;
          end
        end
        S_MAX: begin
          if (sum_q[0] >= sum_q[1] && sum_q[0] >= sum_q[2]) begin
            mx_q <= sum_q[0];
          end else if (sum_q[1] >= sum_q[2]) begin
            mx_q <= sum_q[1];
          end else begin
            mx_q <= sum_q[2];
          end
          ch_q    <= 2'd0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (sum_q[ch_q] == '0) begin
            gain_q[ch_q] <= GainMax;
            ch_q    <= ch_q + 2'd1;
            state_q <= (ch_q == 2'd2) ? S_IDLE : S_DIV;
          end else begin
            state_q <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            gain_q[ch_q] <= quo_sat;
            ch_q    <= ch_q + 2'd1;
            state_q <= (ch_q == 2'd2) ? S_IDLE : S_DIV;
          end
        end
        S_C_MUL: state_q <= S_C_OUT;
        S_C_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/bpwb_checker.sv
`default_nettype none
module bpwb_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input bpwb_pkg::pixel_t  pixel_i,
  input wire               push,
  input wire               full,
  input bpwb_pkg::result_t result_o,
  input wire               empty,
  input wire               pop
);

  logic [2:0] pend_q;
  logic       in_corr, out_xfer;

  assign in_corr  = push && !full && pixel_i.operation;
  assign out_xfer = pop && !empty;

  // Correct pixels taken in but whose results are not yet transferred out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_corr && !out_xfer) begin
      pend_q <= pend_q + 3'd1;
    end else if (out_xfer && !in_corr && pend_q != 3'd0) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(result_o) && !empty))
    else $error("waiting result changed before its transfer");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pend_q != 3'd0))
    else $error("result shown without a pending correct pixel");

  a_bounded_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("more correct pixels in flight than the block can hold");

endmodule

bind bright_pixel_white_balance bpwb_checker u_bpwb_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .pixel_i  (pixel_i),
  .push     (push),
  .full     (full),
  .result_o (result_o),
  .empty    (empty),
  .pop      (pop)
);
`default_nettype wire
